[design/sfjs_pkg.sv]
package sfjs_pkg;

   localparam int FRIC_GEAR_RATIO = 1;
   localparam int FEED_GEAR_RATIO = 36;

   // floor(a / d) == (a * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT for 16-bit a, d <= 64
   localparam int RECIP_SHIFT = 23;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = 16 + RECIP_W;
   localparam logic [RECIP_W-1:0] FRIC_RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + FRIC_GEAR_RATIO - 1) / FRIC_GEAR_RATIO);
   localparam logic [RECIP_W-1:0] FEED_RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + FEED_GEAR_RATIO - 1) / FEED_GEAR_RATIO);

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_RISE          = 3'd0;
   localparam logic [2:0] REG_DIP_INTEGRAL  = 3'd1;
   localparam logic [2:0] REG_DIP_DEPTH     = 3'd2;
   localparam logic [2:0] REG_JAM_TICKS     = 3'd3;
   localparam logic [2:0] REG_BACKOFF_TICKS = 3'd4;

   localparam logic [1:0] CMD_OFF        = 2'd0;
   localparam logic [1:0] CMD_SINGLE     = 2'd1;
   localparam logic [1:0] CMD_CONTINUOUS = 2'd2;

   typedef enum logic [1:0] {
      MODE_OFF        = 2'd0,
      MODE_SINGLE     = 2'd1,
      MODE_CONTINUOUS = 2'd2,
      MODE_BACKOFF    = 2'd3
   } mode_type;

   typedef struct packed {
      logic signed [10:0] rise_threshold;
      logic signed [16:0] dip_integral_threshold;
      logic [11:0]        dip_depth_threshold;
      logic [15:0]        jam_ticks_threshold;
      logic [15:0]        backoff_ticks;
   } cfg_type;

endpackage

[design/sfjs_req_if.sv]
interface sfjs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd_mode;
   logic signed [15:0] fric_speed_cmd;
   logic signed [15:0] feed_speed_cmd;
   logic signed [15:0] fric_speed_meas;
   logic signed [15:0] feed_speed_meas;

   modport source (
      output valid, cmd_mode, fric_speed_cmd, feed_speed_cmd, fric_speed_meas,
             feed_speed_meas,
      input  ready
   );
   modport sink (
      input  valid, cmd_mode, fric_speed_cmd, feed_speed_cmd, fric_speed_meas,
             feed_speed_meas,
      output ready
   );
endinterface

[design/sfjs_rsp_if.sv]
interface sfjs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  exec_mode;
   logic [14:0] exec_fric_speed;
   logic [14:0] exec_feed_speed;
   logic        shot_detected;
   logic        jam_detected;
   logic        backoff_active;

   modport source (
      output valid, exec_mode, exec_fric_speed, exec_feed_speed, shot_detected,
             jam_detected, backoff_active,
      input  ready
   );
   modport sink (
      input  valid, exec_mode, exec_fric_speed, exec_feed_speed, shot_detected,
             jam_detected, backoff_active,
      output ready
   );
endinterface

[design/sfjs_regs.sv]
module sfjs_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sfjs_pkg::ADDR_W-1:0]  paddr,
   input  logic [sfjs_pkg::DATA_W-1:0]  pwdata,
   output logic [sfjs_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output sfjs_pkg::cfg_type            cfg
);
   import sfjs_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_RISE:          cfg_in.rise_threshold         = pwdata[10:0];
            REG_DIP_INTEGRAL:  cfg_in.dip_integral_threshold = pwdata[16:0];
            REG_DIP_DEPTH:     cfg_in.dip_depth_threshold    = pwdata[11:0];
            REG_JAM_TICKS:     cfg_in.jam_ticks_threshold    = pwdata[15:0];
            REG_BACKOFF_TICKS: cfg_in.backoff_ticks          = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RISE:          prdata = DATA_W'(cfg_ff.rise_threshold);
         REG_DIP_INTEGRAL:  prdata = DATA_W'(cfg_ff.dip_integral_threshold);
         REG_DIP_DEPTH:     prdata = DATA_W'(cfg_ff.dip_depth_threshold);
         REG_JAM_TICKS:     prdata = DATA_W'(cfg_ff.jam_ticks_threshold);
         REG_BACKOFF_TICKS: prdata = DATA_W'(cfg_ff.backoff_ticks);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_threshold         <= 11'sd0;
         cfg_ff.dip_integral_threshold <= -17'sd50;
         cfg_ff.dip_depth_threshold    <= 12'd20;
         cfg_ff.jam_ticks_threshold    <= 16'd100;
         cfg_ff.backoff_ticks          <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/shooter_fire_and_jam_supervisor_core.sv]
// Launcher fire and jam supervisor.
// req_if carries one control tick per transaction: commanded mode, commanded
// friction and feed speeds, measured friction and feed speeds. rsp_if returns
// one transaction per tick: executed mode and setpoints, the shot flag, the
// jam flag and the backoff flag. Both channels are valid/ready.
// A tick accepted on req_if goes to the input register, then to the result
// register, which drives rsp_if. Throughput: one tick per cycle unless rsp_if
// stalls; the tick-to-tick state update fits in the single compute stage.
// Receiver stall: the result register holds its transaction, the input
// register still takes one more tick, then req_if.ready drops until the
// result is taken.
// Reset (synchronous, active high): both pipeline stages empty, all tracking
// state zero with executed mode off, single shot locked until off is
// commanded, registers at their defaults. No clearing pass is needed.
// Registers are written over the APB port at byte address 4*index and should
// only change while no tick is in flight.
module shooter_fire_and_jam_supervisor_core (
   input  logic                         clock,
   input  logic                         reset,
   sfjs_req_if.sink                     req_if,
   sfjs_rsp_if.source                   rsp_if,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sfjs_pkg::ADDR_W-1:0]  paddr,
   input  logic [sfjs_pkg::DATA_W-1:0]  pwdata,
   output logic [sfjs_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);
   import sfjs_pkg::*;

   cfg_type cfg;

   sfjs_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input stage
   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_cmd_ff;
   logic signed [15:0] in_fc_ff, in_pc_ff, in_fm_ff, in_pm_ff;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   mode_type           rsp_mode_ff;
   logic [14:0]        rsp_fric_ff, rsp_feed_ff;
   logic               rsp_shot_ff;

   // tracking state
   mode_type           mode_ff, mode_in;
   logic [14:0]        fric_set_ff, fric_set_in;
   logic [14:0]        feed_set_ff, feed_set_in;
   logic [15:0]        last_ff, last_in;
   logic signed [23:0] dip_ff, dip_in;
   logic [15:0]        stall_ff, stall_in;
   logic               jam_ff, jam_in;
   logic               backoff_ff, backoff_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic               single_ff, single_in;

   logic               advance;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_if.ready ? req_if.valid : in_valid_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);

   // speed scaling
   logic [15:0]        fric_abs, feed_abs;
   logic [PROD_W-1:0]  fric_prod, feed_prod, target_prod;
   logic [15:0]        cur, spd;
   logic [14:0]        target;

   assign fric_abs    = in_fm_ff[15] ? 16'(-in_fm_ff) : 16'(in_fm_ff);
   assign feed_abs    = in_pm_ff[15] ? 16'(-in_pm_ff) : 16'(in_pm_ff);
   assign fric_prod   = PROD_W'(fric_abs) * PROD_W'(FRIC_RECIP);
   assign feed_prod   = PROD_W'(feed_abs) * PROD_W'(FEED_RECIP);
   assign target_prod = PROD_W'(fric_set_ff) * PROD_W'(FRIC_RECIP);
   assign cur         = 16'(fric_prod >> RECIP_SHIFT);
   assign spd         = 16'(feed_prod >> RECIP_SHIFT);
   assign target      = 15'(target_prod >> RECIP_SHIFT);

   // shot detection terms
   logic               near_target;
   logic signed [16:0] diff, rise_ext;
   logic signed [24:0] dip_sum;
   logic signed [23:0] dip_sat, dip_thr;
   logic signed [17:0] depth_limit, last_ext;
   logic               shot;

   assign near_target = ({3'b0, cur} * 19'd5) > ({4'b0, target} * 19'd4);
   assign diff        = $signed({1'b0, cur}) - $signed({1'b0, last_ff});
   assign rise_ext    = 17'(cfg.rise_threshold);
   assign dip_sum     = 25'(dip_ff) + 25'(diff);
   assign dip_sat     = (dip_sum[24] != dip_sum[23])
                        ? (dip_sum[24] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}})
                        : dip_sum[23:0];
   assign dip_thr     = 24'(cfg.dip_integral_threshold);
   assign depth_limit = $signed({3'b0, target}) - $signed({6'b0, cfg.dip_depth_threshold});
   assign last_ext    = $signed({2'b0, last_ff});

   // jam and backoff terms
   logic               feed_slow;
   logic [15:0]        stall_next, elapsed_next;

   assign feed_slow    = ({5'b0, spd} * 21'd20) < {6'b0, feed_set_ff};
   assign stall_next   = feed_slow ? ((stall_ff != 16'hFFFF) ? stall_ff + 16'd1 : stall_ff)
                                   : 16'd0;
   assign elapsed_next = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;

   // command terms
   logic               cmd_reject;

   assign cmd_reject = in_fc_ff[15] || in_pc_ff[15] ||
                       ((in_fc_ff == 16'sd0) && (in_pc_ff != 16'sd0));

   always_comb begin
      shot       = 1'b0;
      dip_in     = dip_ff;
      last_in    = cur;
      stall_in   = stall_ff;
      jam_in     = jam_ff;
      backoff_in = backoff_ff;
      elapsed_in = elapsed_ff;
      single_in  = single_ff;
      mode_in    = MODE_OFF;
      fric_set_in = 15'd0;
      feed_set_in = 15'd0;

      if ((fric_set_ff != 15'd0) && near_target) begin
         if (diff < rise_ext) begin
            dip_in = dip_sat;
         end else begin
            if ((dip_ff < dip_thr) && (last_ext < depth_limit)) begin
               shot = 1'b1;
            end
            dip_in = '0;
         end
      end else begin
         dip_in = '0;
      end

      if (!backoff_ff && (feed_set_ff != 15'd0)) begin
         if (stall_next > cfg.jam_ticks_threshold) begin
            jam_in   = 1'b1;
            stall_in = 16'd0;
         end else begin
            jam_in   = 1'b0;
            stall_in = stall_next;
         end
      end

      if (shot && (mode_ff == MODE_SINGLE)) begin
         single_in = 1'b0;
      end

      if (backoff_ff) begin
         elapsed_in = elapsed_next;
         if (elapsed_next > cfg.backoff_ticks) begin
            backoff_in = 1'b0;
         end
      end else if (jam_in) begin
         backoff_in = 1'b1;
         elapsed_in = 16'd0;
      end

      if (cmd_reject) begin
         mode_in = MODE_OFF;
      end else if (backoff_in) begin
         mode_in     = MODE_BACKOFF;
         fric_set_in = in_fc_ff[14:0];
      end else begin
         case (in_cmd_ff)
            CMD_CONTINUOUS: begin
               mode_in     = MODE_CONTINUOUS;
               fric_set_in = in_fc_ff[14:0];
               feed_set_in = in_pc_ff[14:0];
            end
            CMD_SINGLE: begin
               fric_set_in = in_fc_ff[14:0];
               if (single_in) begin
                  mode_in     = MODE_SINGLE;
                  feed_set_in = in_pc_ff[14:0];
               end
            end
            CMD_OFF: begin
               fric_set_in = in_fc_ff[14:0];
               single_in   = 1'b1;
            end
            default: mode_in = MODE_OFF;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_OFF;
         fric_set_ff  <= '0;
         feed_set_ff  <= '0;
         last_ff      <= '0;
         dip_ff       <= '0;
         stall_ff     <= '0;
         jam_ff       <= 1'b0;
         backoff_ff   <= 1'b0;
         elapsed_ff   <= '0;
         single_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff     <= mode_in;
            fric_set_ff <= fric_set_in;
            feed_set_ff <= feed_set_in;
            last_ff     <= last_in;
            dip_ff      <= dip_in;
            stall_ff    <= stall_in;
            jam_ff      <= jam_in;
            backoff_ff  <= backoff_in;
            elapsed_ff  <= elapsed_in;
            single_ff   <= single_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_cmd_ff <= req_if.cmd_mode;
         in_fc_ff  <= req_if.fric_speed_cmd;
         in_pc_ff  <= req_if.feed_speed_cmd;
         in_fm_ff  <= req_if.fric_speed_meas;
         in_pm_ff  <= req_if.feed_speed_meas;
      end
      if (advance) begin
         rsp_mode_ff <= mode_in;
         rsp_fric_ff <= fric_set_in;
         rsp_feed_ff <= feed_set_in;
         rsp_shot_ff <= shot;
      end
   end

   // jam and backoff flags after a tick are the tracking state itself
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.exec_mode       = rsp_mode_ff;
   assign rsp_if.exec_fric_speed = rsp_fric_ff;
   assign rsp_if.exec_feed_speed = rsp_feed_ff;
   assign rsp_if.shot_detected   = rsp_shot_ff;
   assign rsp_if.jam_detected    = jam_ff;
   assign rsp_if.backoff_active  = backoff_ff;

endmodule

[design/sfjs_checker.sv]
module sfjs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  exec_mode,
   input logic [14:0] exec_feed_speed,
   input logic        backoff_active
);
   import sfjs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(exec_mode) && $stable(exec_feed_speed))
      else $error("stalled transaction changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result stage");

   a_backoff_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (exec_mode == MODE_BACKOFF) |-> backoff_active)
      else $error("backoff mode without backoff flag");

   a_feed_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((exec_mode == MODE_OFF) || (exec_mode == MODE_BACKOFF))
      |-> (exec_feed_speed == 15'd0))
      else $error("feed running while off or backing off");

endmodule

bind shooter_fire_and_jam_supervisor_core sfjs_checker u_sfjs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .exec_mode       (rsp_if.exec_mode),
   .exec_feed_speed (rsp_if.exec_feed_speed),
   .backoff_active  (rsp_if.backoff_active)
);

[test/tb_shooter_fire_and_jam_supervisor_core.sv]
module tb_shooter_fire_and_jam_supervisor_core;
   import sfjs_pkg::*;

   localparam logic [1:0] CMD_INVALID = 2'd3;
   localparam int QUIET_LIMIT      = 2000;
   localparam int RSP_CHOKE_CYCLES = 300;

   typedef struct {
      logic [1:0]         cmd_mode;
      logic signed [15:0] fric_cmd;
      logic signed [15:0] feed_cmd;
      logic signed [15:0] fric_meas;
      logic signed [15:0] feed_meas;
   } tick_type;

   typedef struct {
      logic [1:0]  mode;
      logic [14:0] fric;
      logic [14:0] feed;
      logic        shot;
      logic        jam;
      logic        backoff;
   } exec_type;

   class supervisor_mirror;
      logic signed [10:0] rise_thr;
      logic signed [16:0] dip_int_thr;
      logic [11:0]        dip_depth_thr;
      logic [15:0]        jam_thr;
      logic [15:0]        backoff_len;
      mode_type           prev_mode;
      int                 prev_fric_set;
      int                 prev_feed_set;
      int                 last_fric;
      int                 dip_sum;
      int                 stall_cnt;
      int                 backoff_cnt;
      bit                 jam_flag;
      bit                 backoff_flag;
      bit                 single_ok;
      exec_type           exec_expected[$];
      int                 faults;

      function new();
         rise_thr      = '0;
         dip_int_thr   = -17'sd50;
         dip_depth_thr = 12'd20;
         jam_thr       = 16'd100;
         backoff_len   = 16'd100;
         prev_mode     = MODE_OFF;
         prev_fric_set = 0;
         prev_feed_set = 0;
         last_fric     = 0;
         dip_sum       = 0;
         stall_cnt     = 0;
         backoff_cnt   = 0;
         jam_flag      = 1'b0;
         backoff_flag  = 1'b0;
         single_ok     = 1'b0;
         faults        = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_RISE:          rise_thr      = val[10:0];
            REG_DIP_INTEGRAL:  dip_int_thr   = val[16:0];
            REG_DIP_DEPTH:     dip_depth_thr = val[11:0];
            REG_JAM_TICKS:     jam_thr       = val[15:0];
            REG_BACKOFF_TICKS: backoff_len   = val[15:0];
            default: ;
         endcase
      endfunction

      function void note_fault(string msg);
         if (faults < 10) $display("%0t: %0s", $realtime, msg);
         faults++;
      endfunction

      // One control tick: shot check, jam check, backoff timing, command execution.
      function void take_tick(tick_type t);
         int       fc, pc, fm, pm;
         int       target, cur, diff, s, spd;
         int       fset, pset;
         bit       shot;
         mode_type m;
         exec_type e;
         fc   = int'(t.fric_cmd);
         pc   = int'(t.feed_cmd);
         fm   = int'(t.fric_meas);
         pm   = int'(t.feed_meas);
         shot = 1'b0;

         target = prev_fric_set / FRIC_GEAR_RATIO;
         cur    = (fm < 0 ? -fm : fm) / FRIC_GEAR_RATIO;
         if (prev_fric_set != 0 && 5 * cur > 4 * target) begin
            diff = cur - last_fric;
            if (diff < int'(rise_thr)) begin
               s = dip_sum + diff;
               if (s > 8388607) s = 8388607;
               if (s < -8388608) s = -8388608;
               dip_sum = s;
            end else begin
               if (dip_sum < int'(dip_int_thr) && last_fric < target - int'(dip_depth_thr))
                  shot = 1'b1;
               dip_sum = 0;
            end
         end else begin
            dip_sum = 0;
         end
         last_fric = cur & 32'hFFFF;

         if (!backoff_flag && prev_feed_set != 0) begin
            spd = (pm < 0 ? -pm : pm) / FEED_GEAR_RATIO;
            if (20 * spd < prev_feed_set) begin
               if (stall_cnt < 65535) stall_cnt++;
            end else begin
               stall_cnt = 0;
            end
            if (stall_cnt > int'(jam_thr)) begin
               jam_flag  = 1'b1;
               stall_cnt = 0;
            end else begin
               jam_flag = 1'b0;
            end
         end

         if (shot && prev_mode == MODE_SINGLE) single_ok = 1'b0;

         if (backoff_flag) begin
            if (backoff_cnt < 65535) backoff_cnt++;
            if (backoff_cnt > int'(backoff_len)) backoff_flag = 1'b0;
         end else if (jam_flag) begin
            backoff_flag = 1'b1;
            backoff_cnt  = 0;
         end

         if (fc < 0 || pc < 0 || (fc == 0 && pc > 0)) begin
            m = MODE_OFF; fset = 0; pset = 0;
         end else if (backoff_flag) begin
            m = MODE_BACKOFF; fset = fc; pset = 0;
         end else if (t.cmd_mode == CMD_CONTINUOUS) begin
            m = MODE_CONTINUOUS; fset = fc; pset = pc;
         end else if (t.cmd_mode == CMD_SINGLE) begin
            if (single_ok) begin
               m = MODE_SINGLE; fset = fc; pset = pc;
            end else begin
               m = MODE_OFF; fset = fc; pset = 0;
            end
         end else if (t.cmd_mode == CMD_OFF) begin
            m = MODE_OFF; fset = fc; pset = 0;
            single_ok = 1'b1;
         end else begin
            m = MODE_OFF; fset = 0; pset = 0;
         end

         prev_mode     = m;
         prev_fric_set = fset;
         prev_feed_set = pset;

         e.mode    = m;
         e.fric    = 15'(fset);
         e.feed    = 15'(pset);
         e.shot    = shot;
         e.jam     = jam_flag;
         e.backoff = backoff_flag;
         exec_expected.push_back(e);
      endfunction

      function void check_exec(exec_type got);
         exec_type want;
         if (exec_expected.size() == 0) begin
            note_fault($sformatf("unexpected result mode=%0d fric=%0d feed=%0d",
                                 got.mode, got.fric, got.feed));
            return;
         end
         want = exec_expected.pop_front();
         if (want.mode !== got.mode || want.fric !== got.fric || want.feed !== got.feed ||
             want.shot !== got.shot || want.jam !== got.jam || want.backoff !== got.backoff)
            note_fault($sformatf({"mismatch: expected mode=%0d fric=%0d feed=%0d shot=%b ",
                                  "jam=%b backoff=%b, got mode=%0d fric=%0d feed=%0d shot=%b ",
                                  "jam=%b backoff=%b"},
                                 want.mode, want.fric, want.feed, want.shot, want.jam,
                                 want.backoff, got.mode, got.fric, got.feed, got.shot,
                                 got.jam, got.backoff));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   sfjs_req_if req_bus ();
   sfjs_rsp_if rsp_bus ();

   supervisor_mirror mirror;

   logic [1:0] plan_mode;
   int         plan_fric;
   int         plan_feed;
   int         dip_left;
   int         dip_sag;
   bit         feed_stuck;
   int         tx_burst;
   bit         no_gaps;
   bit         choke_rsp;
   int         quiet_cycles;
   tick_type   seen_tick;
   exec_type   seen_exec;

   shooter_fire_and_jam_supervisor_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic tick_type mk(logic [1:0] cmd, int fc, int pc, int fm, int pm);
      tick_type t;
      t.cmd_mode  = cmd;
      t.fric_cmd  = 16'(fc);
      t.feed_cmd  = 16'(pc);
      t.fric_meas = 16'(fm);
      t.feed_meas = 16'(pm);
      return t;
   endfunction

   // Mostly plausible launcher ticks: sticky commands, friction dips and recoveries,
   // feed stall runs. A few ticks are pure noise.
   function automatic tick_type launcher_tick();
      int    r, level, pm;
      if ($urandom_range(0, 99) < 6)
         return mk(2'($urandom), $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 99) < 4) begin
         r = $urandom_range(0, 99);
         if (r < 50) plan_mode = CMD_CONTINUOUS;
         else if (r < 75) plan_mode = CMD_SINGLE;
         else if (r < 95) plan_mode = CMD_OFF;
         else plan_mode = CMD_INVALID;
      end
      if ($urandom_range(0, 99) < 3) begin
         r = $urandom_range(0, 99);
         if (r < 8) plan_fric = 0;
         else if (r < 14) plan_fric = -int'($urandom_range(1, 32768));
         else plan_fric = $urandom_range(200, 32767);
      end
      if ($urandom_range(0, 99) < 3) begin
         r = $urandom_range(0, 99);
         if (r < 10) plan_feed = 0;
         else if (r < 15) plan_feed = -int'($urandom_range(1, 32768));
         else plan_feed = $urandom_range(1, 16000);
      end

      if (dip_left == 0 && $urandom_range(0, 99) < 12) dip_left = $urandom_range(1, 6);
      if (dip_left > 0) begin
         dip_sag += $urandom_range(0, plan_fric > 0 ? plan_fric / 36 : 0);
         dip_left--;
      end else begin
         dip_sag = 0;
      end
      if (plan_fric > 0) level = plan_fric - dip_sag;
      else level = $urandom_range(0, 500);
      level += int'($urandom_range(0, 4)) - 2;
      if (level < 0) level = 0;
      if (level > 32767) level = 32767;
      if ($urandom_range(0, 9) == 0) level = -level;

      if ($urandom_range(0, 99) < 8) feed_stuck = !feed_stuck;
      if (feed_stuck || plan_feed <= 0) pm = $urandom_range(0, 40);
      else pm = plan_feed * FEED_GEAR_RATIO / 20 + FEED_GEAR_RATIO + $urandom_range(0, 2000);
      if (pm > 32767) pm = 32767;
      if ($urandom_range(0, 9) == 0) pm = -pm;

      return mk(plan_mode, plan_fric, plan_feed, level, pm);
   endfunction

   task automatic program_regs(input logic [31:0] v0, v1, v2, v3, v4);
      logic [31:0] vals[5];
      logic [2:0]  idx[5];
      vals = '{v0, v1, v2, v3, v4};
      idx  = '{REG_RISE, REG_DIP_INTEGRAL, REG_DIP_DEPTH, REG_JAM_TICKS, REG_BACKOFF_TICKS};
      for (int i = 0; i < 5; i++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         paddr   <= {idx[i], 2'b00};
         pwdata  <= vals[i];
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         mirror.write_reg(idx[i], vals[i]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // valid is left high after a transaction; it drops ahead of a gap or in settle()
   task automatic send_tick(input tick_type t);
      int gap;
      if (no_gaps) begin
         gap = 0;
      end else if (tx_burst > 0) begin
         tx_burst--;
         gap = 0;
      end else begin
         gap = idle_len();
         if ($urandom_range(0, 99) < 2) tx_burst = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.cmd_mode        <= t.cmd_mode;
      req_bus.fric_speed_cmd  <= t.fric_cmd;
      req_bus.feed_speed_cmd  <= t.feed_cmd;
      req_bus.fric_speed_meas <= t.fric_meas;
      req_bus.feed_speed_meas <= t.feed_meas;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (mirror.exec_expected.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int n);
      for (int i = 0; i < n; i++) send_tick(launcher_tick());
      settle();
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_exec.mode    = rsp_bus.exec_mode;
            seen_exec.fric    = rsp_bus.exec_fric_speed;
            seen_exec.feed    = rsp_bus.exec_feed_speed;
            seen_exec.shot    = rsp_bus.shot_detected;
            seen_exec.jam     = rsp_bus.jam_detected;
            seen_exec.backoff = rsp_bus.backoff_active;
            mirror.check_exec(seen_exec);
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_tick.cmd_mode  = req_bus.cmd_mode;
            seen_tick.fric_cmd  = req_bus.fric_speed_cmd;
            seen_tick.feed_cmd  = req_bus.feed_speed_cmd;
            seen_tick.fric_meas = req_bus.fric_speed_meas;
            seen_tick.feed_meas = req_bus.feed_speed_meas;
            mirror.take_tick(seen_tick);
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int run;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (choke_rsp) begin
            choke_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RSP_CHOKE_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 99) < 4) run = $urandom_range(60, 200);
         else run = $urandom_range(1, 12);
         for (int i = 0; i < run && !choke_rsp; i++) @(posedge clock);
         run = idle_len();
         if (run > 0 && !choke_rsp) begin
            rsp_bus.ready <= 1'b0;
            for (int i = 0; i < run && !choke_rsp; i++) @(posedge clock);
         end
      end
   end

   initial begin
      tick_type directed[$];
      reset                   = 1'b1;
      psel                    = 1'b0;
      penable                 = 1'b0;
      pwrite                  = 1'b1;
      paddr                   = '0;
      pwdata                  = '0;
      req_bus.valid           = 1'b0;
      req_bus.cmd_mode        = CMD_OFF;
      req_bus.fric_speed_cmd  = '0;
      req_bus.feed_speed_cmd  = '0;
      req_bus.fric_speed_meas = '0;
      req_bus.feed_speed_meas = '0;
      plan_mode               = CMD_CONTINUOUS;
      plan_fric               = 8000;
      plan_feed               = 2000;
      dip_left                = 0;
      dip_sag                 = 0;
      feed_stuck              = 1'b0;
      tx_burst                = 0;
      no_gaps                 = 1'b0;
      choke_rsp               = 1'b0;
      quiet_cycles            = 0;
      mirror                  = new();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // short jam and backoff windows so both show up in a few ticks
      program_regs(0, -50, 20, 2, 3);
      directed.push_back(mk(CMD_OFF, 1000, 0, 0, 0));
      directed.push_back(mk(CMD_INVALID, 1000, 100, 0, 0));
      directed.push_back(mk(CMD_CONTINUOUS, -32768, 100, 0, 0));
      directed.push_back(mk(CMD_CONTINUOUS, 100, -1, 0, 0));
      directed.push_back(mk(CMD_CONTINUOUS, 0, 50, 0, 0));
      directed.push_back(mk(CMD_OFF, 0, 0, 0, 0));
      directed.push_back(mk(CMD_SINGLE, 32767, 32767, 32767, 32767));
      directed.push_back(mk(CMD_SINGLE, 32767, 100, 30000, -32768));
      directed.push_back(mk(CMD_SINGLE, 32767, 100, -28000, 32767));
      directed.push_back(mk(CMD_SINGLE, 32767, 100, 32767, 32767));
      directed.push_back(mk(CMD_SINGLE, 32767, 100, -32768, 32767));
      directed.push_back(mk(CMD_OFF, 2000, 0, 2000, 0));
      repeat (5) directed.push_back(mk(CMD_CONTINUOUS, 2000, 500, 2000, 0));
      repeat (5) directed.push_back(mk(CMD_CONTINUOUS, 2000, 500, 2000, 9000));
      directed.push_back(mk(CMD_CONTINUOUS, 0, 0, -32768, -32768));
      directed.push_back(mk(CMD_SINGLE, 1, 1, 1, 1));
      foreach (directed[i]) send_tick(directed[i]);
      settle();

      program_regs(0, -50, 20, 100, 100);
      run_phase(200);
      program_regs(-1024, -65536, 0, 0, 0);
      run_phase(150);
      program_regs(1023, 0, 4095, 65535, 65535);
      run_phase(150);
      for (int k = 0; k < 7; k++) begin
         if (k == 6)
            program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
         else
            program_regs(int'($urandom_range(0, 60)) - 30, -int'($urandom_range(0, 3000)),
                         $urandom_range(0, 200), $urandom_range(0, 25),
                         $urandom_range(0, 25));
         if (k == 1) begin
            choke_rsp = 1'b1;
            no_gaps   = 1'b1;
         end
         run_phase(150);
         no_gaps = 1'b0;
      end

      repeat (4) @(posedge clock);
      if (mirror.exec_expected.size() != 0)
         mirror.note_fault($sformatf("%0d results never arrived",
                                     mirror.exec_expected.size()));
      if (mirror.faults == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[shooter_fire_and_jam_supervisor_core.f]
design/sfjs_pkg.sv
design/sfjs_req_if.sv
design/sfjs_rsp_if.sv
design/sfjs_regs.sv
design/shooter_fire_and_jam_supervisor_core.sv
design/sfjs_checker.sv
test/tb_shooter_fire_and_jam_supervisor_core.sv
